### design/c39_pkg.sv
`timescale 1ns / 1ps
package c39_pkg;

  // Geometry and defaults
  localparam int BARS           = 9;
  localparam int WIDE_COUNT     = 3;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int NCHARS         = 43;
  localparam int IDX_W          = $clog2(BARS);
  localparam int TAB_W          = $clog2(NCHARS);
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 20;
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST = 20'd1000;

  // Delimiter '*'
  localparam logic [8:0] DELIM_PAT  = 9'h094;
  localparam logic [7:0] DELIM_CHAR = 8'h2A;

  // Input op codes
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_START    = 2'd0;
  localparam logic [1:0] STAT_DATA     = 2'd1;
  localparam logic [1:0] STAT_COMPLETE = 2'd2;
  localparam logic [1:0] STAT_INVALID  = 2'd3;

  // Shared comparator outcome
  typedef struct packed {
    logic gt;
    logic eq;
  } c39_cmp_t;

  // Top level to decode sequencer
  typedef struct packed {
    logic start;
    logic lookup;
    logic rev;
    logic ack;
  } c39_req_t;

  // Decode sequencer to top level
  typedef struct packed {
    logic       done;
    logic [8:0] pat;
    logic [7:0] ch;
  } c39_res_t;

  // Bit reverse of a nine bar pattern
  function automatic logic [8:0] rev9(input logic [8:0] p);
    logic [8:0] r;
    r = '0;
    for (int i = 0; i < BARS; i++) begin
      r[BARS-1-i] = p[i];
    end
    return r;
  endfunction

  // Code 39 wide/narrow patterns, table order
  function automatic logic [8:0] pat_of(input logic [TAB_W-1:0] idx);
    logic [8:0] p;
    case (idx)
      6'd0:  p = 9'h034;  6'd1:  p = 9'h121;  6'd2:  p = 9'h061;  6'd3:  p = 9'h160;
      6'd4:  p = 9'h031;  6'd5:  p = 9'h130;  6'd6:  p = 9'h070;  6'd7:  p = 9'h025;
      6'd8:  p = 9'h124;  6'd9:  p = 9'h064;  6'd10: p = 9'h109;  6'd11: p = 9'h049;
      6'd12: p = 9'h148;  6'd13: p = 9'h019;  6'd14: p = 9'h118;  6'd15: p = 9'h058;
      6'd16: p = 9'h00D;  6'd17: p = 9'h10C;  6'd18: p = 9'h04C;  6'd19: p = 9'h01C;
      6'd20: p = 9'h103;  6'd21: p = 9'h043;  6'd22: p = 9'h142;  6'd23: p = 9'h013;
      6'd24: p = 9'h112;  6'd25: p = 9'h052;  6'd26: p = 9'h007;  6'd27: p = 9'h106;
      6'd28: p = 9'h046;  6'd29: p = 9'h016;  6'd30: p = 9'h181;  6'd31: p = 9'h0C1;
      6'd32: p = 9'h1C0;  6'd33: p = 9'h091;  6'd34: p = 9'h190;  6'd35: p = 9'h0D0;
      6'd36: p = 9'h085;  6'd37: p = 9'h184;  6'd38: p = 9'h0A8;  6'd39: p = 9'h0A2;
      6'd40: p = 9'h08A;  6'd41: p = 9'h02A;  6'd42: p = 9'h0C4;
      default: p = 9'h000;
    endcase
    return p;
  endfunction

  // ASCII for a table entry: digits, letters, then the symbols
  function automatic logic [7:0] char_of(input logic [TAB_W-1:0] idx);
    logic [7:0] c;
    if (idx < 6'd10) begin
      c = 8'(idx) + 8'h30;
    end else if (idx < 6'd36) begin
      c = 8'(idx) + 8'h37;
    end else begin
      case (idx)
        6'd36:   c = 8'h2D;
        6'd37:   c = 8'h2E;
        6'd38:   c = 8'h24;
        6'd39:   c = 8'h2F;
        6'd40:   c = 8'h2B;
        6'd41:   c = 8'h25;
        6'd42:   c = 8'h20;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

### design/c39_item_if.sv
`timescale 1ns / 1ps
interface c39_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] edge_time_us;

  modport source (output valid, output op, output edge_time_us, input ready);
  modport sink   (input valid, input op, input edge_time_us, output ready);
endinterface

### design/c39_result_if.sv
`timescale 1ns / 1ps
interface c39_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] char_code;
  logic       reversed_dir;
  logic [8:0] wide_pattern;

  modport source (output valid, output status, output char_code, output reversed_dir,
                  output wide_pattern, input ready);
  modport sink   (input valid, input status, input char_code, input reversed_dir,
                  input wide_pattern, output ready);
endinterface

### design/code39_bar_width_decoder.sv
`timescale 1ns / 1ps
// A clear op or an edge that does not close a character is taken while idle.
// The ninth bar interval starts a decode: comparator passes pick the wide bars, then a
// table search runs for a data character only, and the result is handed over.
// All steps share one comparator; a result waits in an output register.
// Items are held off while a decode runs or its result awaits hand-over.
// Reset (async, active low) clears capture, position, direction and config to defaults.
module code39_bar_width_decoder #(
  parameter int TIME_WIDTH = c39_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  c39_item_if.sink                         item_i,
  c39_result_if.source                     result_o,
  input  logic                             cfg_we_i,
  input  logic [c39_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [c39_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int IW = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
  localparam logic [3:0] LAST_BAR = 4'(c39_pkg::BARS - 1);

  typedef enum logic {
    T_IDLE,
    T_BUSY
  } top_state_e;

  top_state_e                       state_q;
  logic                             scan_en_q;
  logic [c39_pkg::CFG_DATA_W-1:0]   debounce_q;
  logic                             armed_q;
  logic [TIME_WIDTH-1:0]            last_q;
  logic [IW-1:0]                    iv_q [c39_pkg::BARS];
  logic [3:0]                       bar_cnt_q;
  logic [1:0]                       pos_q;
  logic                             rev_q;
  logic [7:0]                       held_q;
  logic                             out_valid_q;
  logic [1:0]                       status_q;
  logic [7:0]                       char_q;
  logic                             rdir_q;
  logic [8:0]                       wpat_q;

  logic [63:0]                      now64;
  logic [TIME_WIDTH-1:0]            now;
  logic [TIME_WIDTH-1:0]            delta;
  logic                             past_deb;
  logic                             in_acc;
  logic                             edge_ok;
  logic                             close_char;
  logic                             out_free;
  c39_pkg::c39_req_t                req;
  c39_pkg::c39_res_t                res;

  logic [7:0]                       dec_ch;
  logic                             dec_rev;
  logic [1:0]                       dec_status;
  logic [7:0]                       out_ch;
  logic [1:0]                       pos_n;
  logic                             rev_n;

  // Edge timing and debounce
  assign now64    = 64'(item_i.edge_time_us);
  assign now      = now64[TIME_WIDTH-1:0];
  assign delta    = now - last_q;
  assign past_deb = 64'(delta) > 64'(debounce_q);

  assign item_i.ready = (state_q == T_IDLE);
  assign in_acc       = item_i.valid && item_i.ready;
  assign edge_ok      = in_acc && (item_i.op == c39_pkg::OP_EDGE) && scan_en_q && past_deb;
  assign close_char   = edge_ok && armed_q && (bar_cnt_q == LAST_BAR);
  assign out_free     = !out_valid_q || result_o.ready;

  // Decode request
  assign req.start  = close_char;
  assign req.lookup = ((pos_q + 2'd1) == 2'd2);
  assign req.rev    = rev_q;
  assign req.ack    = (state_q == T_BUSY) && res.done && out_free;

  c39_decode_seq #(.IW(IW)) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .iv_i   (iv_q),
    .req_i  (req),
    .res_o  (res)
  );

  // Character classification by position
  always_comb begin
    dec_rev = rev_q;
    if (pos_q == 2'd2) begin
      dec_ch = res.ch;
    end else if (res.pat == c39_pkg::DELIM_PAT) begin
      dec_ch = c39_pkg::DELIM_CHAR;
    end else if (res.pat == c39_pkg::rev9(c39_pkg::DELIM_PAT)) begin
      dec_ch  = c39_pkg::DELIM_CHAR;
      dec_rev = 1'b1;
    end else begin
      dec_ch = '0;
    end

    pos_n = pos_q;
    rev_n = dec_rev;
    if (dec_ch == 8'd0) begin
      dec_status = c39_pkg::STAT_INVALID;
      out_ch     = '0;
      pos_n      = '0;
      rev_n      = 1'b0;
    end else if (pos_q == 2'd2) begin
      dec_status = c39_pkg::STAT_DATA;
      out_ch     = dec_ch;
    end else if (pos_q == 2'd3) begin
      dec_status = c39_pkg::STAT_COMPLETE;
      out_ch     = held_q;
      pos_n      = '0;
      rev_n      = 1'b0;
    end else begin
      dec_status = c39_pkg::STAT_START;
      out_ch     = dec_ch;
    end
  end

  // Bar interval store
  always_ff @(posedge clk_i) begin
    if (edge_ok && armed_q) begin
      iv_q[bar_cnt_q] <= delta[IW-1:0];
    end
  end

  // Control, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      scan_en_q   <= 1'b0;
      debounce_q  <= c39_pkg::DEBOUNCE_RST;
      armed_q     <= 1'b0;
      last_q      <= '0;
      bar_cnt_q   <= '0;
      pos_q       <= '0;
      rev_q       <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      char_q      <= '0;
      rdir_q      <= 1'b0;
      wpat_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          c39_pkg::CFG_SCAN_ENABLE: scan_en_q  <= cfg_wdata_i[0];
          c39_pkg::CFG_DEBOUNCE:    debounce_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      // Output valid: set on hand-over, dropped once taken
      if (req.ack) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        T_IDLE: begin
          if (in_acc && (item_i.op == c39_pkg::OP_CLEAR)) begin
            armed_q   <= 1'b0;
            bar_cnt_q <= '0;
          end else if (edge_ok) begin
            last_q <= now;
            if (!armed_q) begin
              armed_q <= 1'b1;
            end else if (close_char) begin
              armed_q   <= 1'b0;
              bar_cnt_q <= '0;
              pos_q     <= pos_q + 2'd1;
              state_q   <= T_BUSY;
            end else begin
              bar_cnt_q <= bar_cnt_q + 4'd1;
            end
          end
        end
        T_BUSY: begin
          if (req.ack) begin
            status_q    <= dec_status;
            char_q      <= out_ch;
            rdir_q      <= dec_rev;
            wpat_q      <= res.pat;
            pos_q       <= pos_n;
            rev_q       <= rev_n;
            if (dec_status == c39_pkg::STAT_DATA) begin
              held_q <= dec_ch;
            end
            state_q <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.status       = status_q;
  assign result_o.char_code    = char_q;
  assign result_o.reversed_dir = rdir_q;
  assign result_o.wide_pattern = wpat_q;

`ifndef SYNTHESIS
  // A finished decode is only seen while a character is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> state_q == T_BUSY)
    else $error("decode result outside busy phase");

  // Exactly three wide bars in every decoded pattern
  a_three_wide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> $countones(res.pat) == c39_pkg::WIDE_COUNT)
    else $error("wide pattern does not hold three wide bars");

  // Between characters the position never rests on the stop slot
  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == T_IDLE |-> pos_q != 2'd3)
    else $error("character position left on stop slot");

  // Reversed direction only after a start delimiter
  a_rev_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_IDLE && rev_q) |-> pos_q != 2'd0)
    else $error("reversed flag set with no start delimiter");
`endif

endmodule

### design/c39_cmp_unit.sv
`timescale 1ns / 1ps
// Shared magnitude/equality comparator
module c39_cmp_unit #(
  parameter int W = 32
) (
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  output c39_pkg::c39_cmp_t  cmp_o
);

  assign cmp_o.gt = (a_i > b_i);
  assign cmp_o.eq = (a_i == b_i);

endmodule

### design/c39_decode_seq.sv
`timescale 1ns / 1ps
// Picks the three widest bars over three passes, then searches the table when a lookup
// is requested, all through one shared comparator.
module c39_decode_seq #(
  parameter int IW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IW-1:0]        iv_i [c39_pkg::BARS],
  input  c39_pkg::c39_req_t    req_i,
  output c39_pkg::c39_res_t    res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LOOK,
    S_DONE
  } seq_state_e;

  localparam logic [c39_pkg::IDX_W-1:0] LAST_BAR  = c39_pkg::IDX_W'(c39_pkg::BARS - 1);
  localparam logic [1:0]                LAST_PASS = 2'(c39_pkg::WIDE_COUNT - 1);
  localparam logic [c39_pkg::TAB_W-1:0] LAST_TAB  = c39_pkg::TAB_W'(c39_pkg::NCHARS - 1);

  seq_state_e                    state_q;
  logic [1:0]                    pass_q;
  logic [c39_pkg::IDX_W-1:0]     idx_q;
  logic [c39_pkg::IDX_W-1:0]     best_q;
  logic [IW-1:0]                 best_val_q;
  logic                          have_q;
  logic [c39_pkg::BARS-1:0]      picked_q;
  logic                          lookup_q;
  logic                          rev_q;
  logic [c39_pkg::TAB_W-1:0]     tab_q;
  logic [8:0]                    pat_q;
  logic [8:0]                    key_q;
  logic [7:0]                    ch_q;

  logic [IW-1:0]                 cand;
  logic [IW-1:0]                 op_a;
  logic [IW-1:0]                 op_b;
  c39_pkg::c39_cmp_t             cmp;
  logic                          take;
  logic [c39_pkg::IDX_W-1:0]     sel_idx;
  logic [c39_pkg::BARS-1:0]      picked_d;
  logic [8:0]                    pat_d;

  // Operand selection for the shared comparator
  assign cand = iv_i[idx_q];
  always_comb begin
    if (state_q == S_LOOK) begin
      op_a = IW'(c39_pkg::pat_of(tab_q));
      op_b = IW'(key_q);
    end else begin
      op_a = cand;
      op_b = best_val_q;
    end
  end

  c39_cmp_unit #(.W(IW)) u_cmp (
    .a_i   (op_a),
    .b_i   (op_b),
    .cmp_o (cmp)
  );

  // Strict greater keeps the lower index on a tie
  assign take     = !picked_q[idx_q] && (!have_q || cmp.gt);
  assign sel_idx  = take ? idx_q : best_q;
  assign picked_d = picked_q | (c39_pkg::BARS'(1) << sel_idx);
  assign pat_d    = c39_pkg::rev9(picked_d);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pass_q     <= '0;
      idx_q      <= '0;
      best_q     <= '0;
      best_val_q <= '0;
      have_q     <= 1'b0;
      picked_q   <= '0;
      lookup_q   <= 1'b0;
      rev_q      <= 1'b0;
      tab_q      <= '0;
      pat_q      <= '0;
      key_q      <= '0;
      ch_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            state_q  <= S_SCAN;
            pass_q   <= '0;
            idx_q    <= '0;
            have_q   <= 1'b0;
            picked_q <= '0;
            lookup_q <= req_i.lookup;
            rev_q    <= req_i.rev;
          end
        end
        S_SCAN: begin
          if (take) begin
            best_q     <= idx_q;
            best_val_q <= cand;
          end
          if (idx_q == LAST_BAR) begin
            picked_q <= picked_d;
            idx_q    <= '0;
            have_q   <= 1'b0;
            if (pass_q == LAST_PASS) begin
              pat_q <= pat_d;
              key_q <= rev_q ? c39_pkg::rev9(pat_d) : pat_d;
              tab_q <= '0;
              ch_q  <= '0;
              state_q <= lookup_q ? S_LOOK : S_DONE;
            end else begin
              pass_q <= pass_q + 2'd1;
            end
          end else begin
            idx_q  <= idx_q + 1'b1;
            have_q <= have_q | take;
          end
        end
        S_LOOK: begin
          if (cmp.eq) begin
            ch_q    <= c39_pkg::char_of(tab_q);
            state_q <= S_DONE;
          end else if (tab_q == LAST_TAB) begin
            ch_q    <= '0;
            state_q <= S_DONE;
          end else begin
            tab_q <= tab_q + 1'b1;
          end
        end
        S_DONE: begin
          if (req_i.ack) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.done = (state_q == S_DONE);
  assign res_o.pat  = pat_q;
  assign res_o.ch   = ch_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int DRAIN_CYCLES = 80;       // longest decode plus hand-over, with margin
  localparam int CYCLE_LIMIT  = 500_000;

  // Code 39 wide/narrow patterns and their characters, table order
  localparam logic [8:0] CODE39_PAT [c39_pkg::NCHARS] = '{
    9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130, 9'h070, 9'h025, 9'h124, 9'h064,
    9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C, 9'h01C,
    9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016,
    9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0, 9'h085, 9'h184, 9'h0A8, 9'h0A2,
    9'h08A, 9'h02A, 9'h0C4
  };
  localparam logic [8*c39_pkg::NCHARS-1:0] CODE39_ASCII =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-.$/+% ";

  typedef struct {
    logic        op;
    logic [31:0] stamp;
  } scan_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] char_code;
    logic       reversed_dir;
    logic [8:0] wide_pattern;
  } char_result_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Driven values, known from time zero
  logic                           tx_valid  = 1'b0;
  logic                           tx_op     = c39_pkg::OP_EDGE;
  logic [31:0]                    tx_stamp  = '0;
  logic                           rx_ready  = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [c39_pkg::CFG_IDX_W-1:0]  cfg_idx   = c39_pkg::CFG_SCAN_ENABLE;
  logic [c39_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  c39_item_if   item_if ();
  c39_result_if res_if ();

  assign item_if.valid        = tx_valid;
  assign item_if.op           = tx_op;
  assign item_if.edge_time_us = tx_stamp;
  assign res_if.ready         = rx_ready;

  code39_bar_width_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .result_o    (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Queues and counters
  scan_item_t   pending_edges [$];
  char_result_t expected_chars [$];
  int           queued_items   = 0;
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           tx_gap         = 0;
  int           tx_quiet       = 0;
  int           rx_hold        = 0;
  int           rx_quiet       = 0;
  logic [31:0]  scene_us       = '0;

  // Decoder state mirror
  logic                           cfg_scan_on   = 1'b0;
  logic [c39_pkg::CFG_DATA_W-1:0] cfg_debounce  = c39_pkg::DEBOUNCE_RST;
  logic                           seen_first    = 1'b0;
  logic [31:0]                    prev_edge_us  = '0;
  logic [31:0]                    bar_width_q [c39_pkg::BARS];
  logic [3:0]                     bar_seen      = '0;
  logic [1:0]                     char_slot     = '0;
  logic                           scan_reversed = 1'b0;
  logic [7:0]                     held_ascii    = '0;

  initial begin
    for (int i = 0; i < c39_pkg::BARS; i++) bar_width_q[i] = '0;
  end

  function automatic logic [8:0] mirror9(logic [8:0] p);
    logic [8:0] r;
    r = {<<{p}};
    return r;
  endfunction

  function automatic void drop_capture();
    for (int i = 0; i < c39_pkg::BARS; i++) bar_width_q[i] = '0;
    bar_seen   = '0;
    seen_first = 1'b0;
  endfunction

  // Three longest bars are wide; on a tie the earlier bar wins
  function automatic logic [8:0] wide_of_bars();
    logic [8:0] p;
    int longer;
    p = '0;
    for (int i = 0; i < c39_pkg::BARS; i++) begin
      longer = 0;
      for (int j = 0; j < c39_pkg::BARS; j++) begin
        if (bar_width_q[j] > bar_width_q[i] || (bar_width_q[j] == bar_width_q[i] && j < i))
          longer++;
      end
      if (longer < c39_pkg::WIDE_COUNT) p[c39_pkg::BARS-1-i] = 1'b1;
    end
    return p;
  endfunction

  function automatic logic [7:0] table_char(logic [8:0] p);
    for (int i = 0; i < c39_pkg::NCHARS; i++) begin
      if (CODE39_PAT[i] == p) return CODE39_ASCII[8*(c39_pkg::NCHARS-1-i) +: 8];
    end
    return 8'h00;
  endfunction

  // Advance the mirrored state by one accepted item, queueing any decoded character
  function automatic void track_item(logic op, logic [31:0] stamp);
    logic [31:0]  gap;
    logic [8:0]   p;
    logic [7:0]   ch;
    char_result_t r;
    gap = stamp - prev_edge_us;
    if (op == c39_pkg::OP_CLEAR) begin
      drop_capture();
      return;
    end
    if (!cfg_scan_on) return;
    if (gap <= {12'd0, cfg_debounce}) return;
    if (!seen_first) begin
      seen_first = 1'b1;
    end else begin
      if (bar_seen < c39_pkg::BARS) bar_width_q[bar_seen] = gap;
      bar_seen = bar_seen + 4'd1;
      if (bar_seen >= c39_pkg::BARS) begin
        char_slot = char_slot + 2'd1;
        p = wide_of_bars();
        if (char_slot == 2'd2) begin
          ch = table_char(scan_reversed ? mirror9(p) : p);
        end else if (p == c39_pkg::DELIM_PAT) begin
          ch = c39_pkg::DELIM_CHAR;
        end else if (p == mirror9(c39_pkg::DELIM_PAT)) begin
          ch = c39_pkg::DELIM_CHAR;
          scan_reversed = 1'b1;
        end else begin
          ch = 8'h00;
        end
        r.reversed_dir = scan_reversed;
        r.wide_pattern = p;
        if (ch == 8'h00) begin
          r.status      = c39_pkg::STAT_INVALID;
          char_slot     = '0;
          scan_reversed = 1'b0;
        end else if (char_slot == 2'd2) begin
          held_ascii = ch;
          r.status   = c39_pkg::STAT_DATA;
        end else if (char_slot == 2'd3) begin
          r.status      = c39_pkg::STAT_COMPLETE;
          ch            = held_ascii;
          char_slot     = '0;
          scan_reversed = 1'b0;
        end else begin
          r.status = c39_pkg::STAT_START;
        end
        r.char_code = ch;
        expected_chars.push_back(r);
        drop_capture();
      end
    end
    prev_edge_us = stamp;
  endfunction

  // Per-item wait, with occasional stretches of none
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Item source
  always @(posedge clk_i or negedge rst_ni) begin : edge_source
    scan_item_t nxt;
    if (!rst_ni) begin
      tx_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (tx_valid && item_if.ready) track_item(tx_op, tx_stamp);
      if (!tx_valid || item_if.ready) begin
        if (tx_gap > 0) begin
          tx_valid <= 1'b0;
          tx_gap   <= tx_gap - 1;
        end else if (pending_edges.size() != 0) begin
          nxt = pending_edges.pop_front();
          tx_valid <= 1'b1;
          tx_op    <= nxt.op;
          tx_stamp <= nxt.stamp;
          tx_gap   <= draw_wait(tx_quiet);
        end else begin
          tx_valid <= 1'b0;
        end
      end
    end
  end

  // Result sink and field check
  always @(posedge clk_i or negedge rst_ni) begin : char_sink
    char_result_t want;
    int           hold_n;
    if (!rst_ni) begin
      rx_ready <= 1'b0;
      rx_hold  <= 0;
    end else begin
      if (res_if.valid && rx_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result: status %0d char_code %0h", res_if.status,
                 res_if.char_code);
          mismatch_count++;
        end else begin
          want = expected_chars.pop_front();
          if (res_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_if.status);
            mismatch_count++;
          end
          if (res_if.char_code !== want.char_code) begin
            $error("char_code: expected %0h, actual %0h", want.char_code, res_if.char_code);
            mismatch_count++;
          end
          if (res_if.reversed_dir !== want.reversed_dir) begin
            $error("reversed_dir: expected %0d, actual %0d", want.reversed_dir,
                   res_if.reversed_dir);
            mismatch_count++;
          end
          if (res_if.wide_pattern !== want.wide_pattern) begin
            $error("wide_pattern: expected %0h, actual %0h", want.wide_pattern,
                   res_if.wide_pattern);
            mismatch_count++;
          end
        end
        hold_n = draw_wait(rx_quiet);
        rx_hold  <= hold_n;
        rx_ready <= (hold_n == 0);
      end else if (rx_hold > 0) begin
        rx_hold  <= rx_hold - 1;
        rx_ready <= (rx_hold == 1);
      end else begin
        rx_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[code39_bar_width_decoder] ERROR");
      $finish;
    end
  end

  // Stimulus builders
  function automatic void add_edge(logic [31:0] stamp);
    scan_item_t it;
    it.op    = c39_pkg::OP_EDGE;
    it.stamp = stamp;
    pending_edges.push_back(it);
    queued_items++;
  endfunction

  function automatic void add_clear();
    scan_item_t it;
    it.op    = c39_pkg::OP_CLEAR;
    it.stamp = $urandom;
    pending_edges.push_back(it);
    queued_items++;
  endfunction

  // Arming edge then bar edges for pattern p; cut < 10 stops part-way
  function automatic void add_symbol(logic [8:0] p, int unsigned nb, int unsigned nj,
                                     int unsigned wb, int unsigned wj, bit bounce, int cut);
    int          bounce_at;
    logic [31:0] step;
    bounce_at = bounce ? $urandom_range(0, cut - 1) : 10;
    for (int k = 0; k < cut; k++) begin
      // a bounce lands within the debounce window of the last edge
      if (k == bounce_at) add_edge(scene_us + $urandom_range(0, cfg_debounce));
      if (k == 0)
        step = cfg_debounce + 1 + $urandom_range(0, 3000);
      else if (p[c39_pkg::BARS-k])
        step = wb + $urandom_range(0, wj);
      else
        step = nb + $urandom_range(0, nj);
      scene_us = scene_us + step;
      add_edge(scene_us);
    end
  endfunction

  // Clean timing: every wide bar longer than every narrow one
  function automatic void symbol_for(logic [8:0] p, int cut);
    int unsigned nb, nj, wb, wj;
    nb = cfg_debounce + 1 + $urandom_range(0, 400);
    nj = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 300);
    wb = nb + nj + 1 + $urandom_range(0, nb);
    wj = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 500);
    add_symbol(p, nb, nj, wb, wj, $urandom_range(0, 7) == 0, cut);
  endfunction

  function automatic logic [8:0] rand_pattern();
    logic [8:0] p;
    int         pick;
    pick = $urandom_range(0, 3);
    if (pick < 2) begin
      p = CODE39_PAT[$urandom_range(0, c39_pkg::NCHARS - 1)];
      if ($urandom_range(0, 1)) p = mirror9(p);
    end else if (pick == 2) begin
      p = $urandom_range(0, 1) ? c39_pkg::DELIM_PAT : mirror9(c39_pkg::DELIM_PAT);
    end else begin
      p = '0;
      while ($countones(p) < c39_pkg::WIDE_COUNT) p[$urandom_range(0, c39_pkg::BARS - 1)] = 1'b1;
    end
    return p;
  endfunction

  // Start delimiter, data character, stop delimiter
  function automatic void add_barcode();
    logic       backwards;
    logic [8:0] delim;
    logic [8:0] data;
    backwards = 1'($urandom_range(0, 1));
    delim = backwards ? mirror9(c39_pkg::DELIM_PAT) : c39_pkg::DELIM_PAT;
    data  = CODE39_PAT[$urandom_range(0, c39_pkg::NCHARS - 1)];
    if (backwards) data = mirror9(data);
    symbol_for(delim, 10);
    symbol_for(data, 10);
    symbol_for($urandom_range(0, 1) ? c39_pkg::DELIM_PAT : mirror9(c39_pkg::DELIM_PAT), 10);
  endfunction

  // Mostly whole barcodes, the rest stray symbols, part symbols and noise
  function automatic void random_run(int n);
    int goal;
    int pick;
    goal = queued_items + n;
    add_clear();
    scene_us = $urandom;
    while (queued_items < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        add_barcode();
      end else if (pick < 74) begin
        symbol_for(rand_pattern(), 10);
      end else if (pick < 82) begin
        // near-equal widths with frequent ties
        add_symbol(9'($urandom), cfg_debounce + 1, 7, cfg_debounce + 1, 7, 1'b0, 10);
      end else if (pick < 92) begin
        symbol_for(rand_pattern(), $urandom_range(1, 9));
        add_clear();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1)) begin
            add_clear();
          end else begin
            scene_us = $urandom;
            add_edge(scene_us);
          end
        end
        add_clear();
      end
    end
  endfunction

  task automatic write_reg(logic [c39_pkg::CFG_IDX_W-1:0] idx,
                           logic [c39_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    if (idx == c39_pkg::CFG_SCAN_ENABLE) cfg_scan_on = value[0];
    else cfg_debounce = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every item is taken and every result has come back
  task automatic drain();
    while (pending_edges.size() != 0 || tx_valid) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // scanning off after reset: edge ignored, clear still acts
    add_edge(32'hFFFF_FFFF);
    add_clear();
    drain();

    write_reg(c39_pkg::CFG_SCAN_ENABLE, 20'd1);
    // start delimiter across the time wrap, narrow bars one above the debounce limit
    scene_us = 32'hFFFF_FFFF - 32'd8000;
    add_symbol(c39_pkg::DELIM_PAT, cfg_debounce + 1, 0, 2500, 0, 1'b1, 10);
    // all bars equal: the first three take the wide slots
    add_symbol(9'h000, 1500, 0, 1500, 0, 1'b0, 10);
    // part of a symbol, then the capture is cleared
    add_symbol(c39_pkg::DELIM_PAT, 1200, 0, 3000, 0, 1'b0, 3);
    add_clear();
    drain();

    random_run(500);
    drain();
    write_reg(c39_pkg::CFG_DEBOUNCE, '0);
    random_run(300);
    drain();
    write_reg(c39_pkg::CFG_DEBOUNCE, 20'd1000000);
    random_run(200);
    drain();
    write_reg(c39_pkg::CFG_SCAN_ENABLE, 20'd0);
    random_run(60);
    drain();
    write_reg(c39_pkg::CFG_SCAN_ENABLE, 20'd1);
    repeat (3) begin
      write_reg(c39_pkg::CFG_DEBOUNCE, 20'($urandom_range(0, 5000)));
      random_run(200);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("[code39_bar_width_decoder] OK");
    end else begin
      $display("[code39_bar_width_decoder] ERROR");
    end
    $finish;
  end

endmodule
